@@ rtl/rsp_pkg.sv @@
// Shared constants and types for the range sum pair counter.
// No dependencies; used by range_sum_pair_counter.
`default_nettype none

package rsp_pkg;

	// Sizing of the prefix sum store
	localparam int MAX_ITEMS = 1024;
	localparam int STORE_LEN = MAX_ITEMS + 1;
	localparam int SC_W      = $clog2(STORE_LEN + 1);
	localparam int AW        = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

	// Fixed field widths
	localparam int VAL_W  = 32;
	localparam int PS_W   = 42;
	localparam int D_W    = PS_W + 1;
	localparam int CH_W   = 11;
	localparam int TOT_W  = 20;
	localparam int CW     = (SC_W > CH_W) ? SC_W : CH_W;

	localparam logic [CH_W-1:0] CNT_MAX = '1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 1'd1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

endpackage

`default_nettype wire

@@ rtl/rsp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                wdata,
	input  logic                            re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/range_sum_pair_counter.sv @@
// Range sum pair counter: per element, counts earlier prefix sums p with
// s - range_high <= p <= s - range_low. n = number of stored prefix sums
// (1 .. MAX_ITEMS+1); one store entry is read per cycle, so that memory read
// port sets the rate at which a request's n entries are scanned. One request
// in flight; the next is taken while a result waits at the output.
// Reset (arst_n low): bounds 0, prefix sum 0, store holds only zero; no clear pass.
// Depends on rsp_pkg and rsp_ram.
`default_nettype none

module range_sum_pair_counter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [31:0]                   s_tdata,   // [31:0] value
	input  logic [0:0]                    s_tuser,   // [0] first
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata,   // [10:0] count_here, [30:11] running_total
	output logic [0:0]                    m_tuser,   // [0] overflow
	input  logic                          cfg_we,
	input  logic [rsp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);

	rsp_pkg::state_t state_q;

	logic signed [rsp_pkg::VAL_W-1:0] lo_q, hi_q;
	logic [rsp_pkg::PS_W-1:0]         ps_q;
	logic [rsp_pkg::SC_W-1:0]         st_cnt_q;
	logic [rsp_pkg::SC_W-1:0]         idx_q;
	logic [rsp_pkg::SC_W-1:0]         cnt_q;
	logic [rsp_pkg::TOT_W-1:0]        tot_q;

	logic                             v_s1, zero_s1, v_s2;
	logic signed [rsp_pkg::D_W-1:0]   d_s2;

	logic                             m_tvalid_q;
	logic [rsp_pkg::CH_W-1:0]         ch_q;
	logic [rsp_pkg::TOT_W-1:0]        rt_q;
	logic                             ovf_q;

	logic                             in_fire, issue, done_fire, has_room;
	logic                             mem_we, mem_re;
	logic [rsp_pkg::AW-1:0]           mem_waddr, mem_raddr;
	logic [rsp_pkg::PS_W-1:0]         mem_rdata, p_sel, ps_base;
	logic [rsp_pkg::CW-1:0]           cnt_ext;
	logic [rsp_pkg::CH_W-1:0]         cnt_sat;
	logic [rsp_pkg::TOT_W:0]          tot_sum;
	logic [rsp_pkg::TOT_W-1:0]        tot_next;
	logic signed [rsp_pkg::D_W-1:0]   lo_ext, hi_ext;
	logic                             hit;

	assign s_tready  = (state_q == rsp_pkg::ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign issue     = (state_q == rsp_pkg::ST_SCAN);
	assign done_fire = (state_q == rsp_pkg::ST_DONE) && (!m_tvalid_q || m_tready);
	assign has_room  = (st_cnt_q < rsp_pkg::SC_W'(rsp_pkg::STORE_LEN));

	// Entry 0 is always zero and never lives in the RAM; RAM slot k holds entry k+1.
	assign mem_re    = issue && (idx_q != '0);
	assign mem_raddr = rsp_pkg::AW'(idx_q - rsp_pkg::SC_W'(1));
	assign mem_we    = done_fire && has_room;
	assign mem_waddr = rsp_pkg::AW'(st_cnt_q - rsp_pkg::SC_W'(1));

	rsp_ram #(
		.WIDTH(rsp_pkg::PS_W),
		.DEPTH(rsp_pkg::MAX_ITEMS)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(ps_q),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign ps_base = s_tuser[0] ? '0 : ps_q;
	assign p_sel   = zero_s1 ? '0 : mem_rdata;
	assign lo_ext  = {{(rsp_pkg::D_W-rsp_pkg::VAL_W){lo_q[rsp_pkg::VAL_W-1]}}, lo_q};
	assign hi_ext  = {{(rsp_pkg::D_W-rsp_pkg::VAL_W){hi_q[rsp_pkg::VAL_W-1]}}, hi_q};
	assign hit     = (d_s2 >= lo_ext) && (d_s2 <= hi_ext);

	assign cnt_ext  = rsp_pkg::CW'(cnt_q);
	assign cnt_sat  = (cnt_ext > rsp_pkg::CW'(rsp_pkg::CNT_MAX)) ? rsp_pkg::CNT_MAX
	                                                             : cnt_ext[rsp_pkg::CH_W-1:0];
	assign tot_sum  = {1'b0, tot_q} + (rsp_pkg::TOT_W+1)'(cnt_sat);
	assign tot_next = tot_sum[rsp_pkg::TOT_W] ? '1 : tot_sum[rsp_pkg::TOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= '0;
			hi_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rsp_pkg::REG_RANGE_LOW:  lo_q <= cfg_data;
				rsp_pkg::REG_RANGE_HIGH: hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rsp_pkg::ST_IDLE;
			ps_q       <= '0;
			st_cnt_q   <= rsp_pkg::SC_W'(1);
			tot_q      <= '0;
			idx_q      <= '0;
			cnt_q      <= '0;
			v_s1       <= 1'b0;
			zero_s1    <= 1'b0;
			v_s2       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			v_s1    <= issue;
			zero_s1 <= (idx_q == '0);
			v_s2    <= v_s1;
			if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (v_s2 && hit) begin
				cnt_q <= cnt_q + rsp_pkg::SC_W'(1);
			end

			unique case (state_q)
				rsp_pkg::ST_IDLE: begin
					if (in_fire) begin
						ps_q <= ps_base + {{(rsp_pkg::PS_W-rsp_pkg::VAL_W){s_tdata[31]}},
						                   s_tdata};
						if (s_tuser[0]) begin
							st_cnt_q <= rsp_pkg::SC_W'(1);
							tot_q    <= '0;
						end
						idx_q   <= '0;
						cnt_q   <= '0;
						state_q <= rsp_pkg::ST_SCAN;
					end
				end
				rsp_pkg::ST_SCAN: begin
					idx_q <= idx_q + rsp_pkg::SC_W'(1);
					if (idx_q == st_cnt_q - rsp_pkg::SC_W'(1)) begin
						state_q <= rsp_pkg::ST_DRAIN;
					end
				end
				rsp_pkg::ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= rsp_pkg::ST_DONE;
					end
				end
				rsp_pkg::ST_DONE: begin
					if (done_fire) begin
						m_tvalid_q <= 1'b1;
						tot_q      <= tot_next;
						if (has_room) begin
							st_cnt_q <= st_cnt_q + rsp_pkg::SC_W'(1);
						end
						state_q <= rsp_pkg::ST_IDLE;
					end
				end
				default: state_q <= rsp_pkg::ST_IDLE;
			endcase
		end
	end

	// Stage 2: difference s - p over 43 bits so it never wraps
	always_ff @(posedge clk) begin
		d_s2 <= $signed({ps_q[rsp_pkg::PS_W-1], ps_q}) -
		        $signed({p_sel[rsp_pkg::PS_W-1], p_sel});
		if (done_fire) begin
			ch_q  <= cnt_sat;
			rt_q  <= tot_next;
			ovf_q <= !has_room;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, rt_q, ch_q};
	assign m_tuser  = ovf_q;

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("store read and write in the same cycle");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_cnt_q >= rsp_pkg::SC_W'(1)) &&
		(st_cnt_q <= rsp_pkg::SC_W'(rsp_pkg::STORE_LEN)))
		else $error("stored count out of range");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= st_cnt_q)
		else $error("match count exceeds stored entries");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!v_s1 && !v_s2))
		else $error("request accepted with compare pipeline busy");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		done_fire |=> m_tvalid)
		else $error("result not presented after completion");

endmodule

`default_nettype wire
